/* sv/cks_pkg.sv */
// shared types and constants for the ones' complement checksum engine
// no dependencies; imported by every module of the block
`default_nettype none

package cks_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned SumW  = 32;
  localparam int unsigned ModeW = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_CLEAR    = 3'd0,
    MODE_ADD_WORD = 3'd1,
    MODE_ADD_BYTE = 3'd2,
    MODE_FINISH   = 3'd3,
    MODE_BUMP_SEQ = 3'd4,
    MODE_LOAD_SEQ = 3'd5
  } mode_e;

  // running sum and sequence captured for the fold stage
  typedef struct packed {
    logic [SumW-1:0]  sum;
    logic [WordW-1:0] seq;
  } snap_t;

endpackage

`default_nettype wire

/* sv/cks_accum.sv */
// accumulate stage: owns the running sum and the sequence counter
// depends on cks_pkg; feeds a snapshot to cks_fold for finish and bump
`default_nettype none

module cks_accum import cks_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire logic [WordW-1:0] data_i,
  output logic                  snap_valid_o,
  input  wire logic             snap_ready_i,
  output snap_t                 snap_o
);

  logic [SumW-1:0]  sum_q, sum_d;
  logic [WordW-1:0] seq_q, seq_d, seq_inc;
  logic             snap_v_q, snap_v_d;
  snap_t            snap_q;
  logic             fire, emit;
  mode_e            mode;

  assign mode    = mode_e'(mode_i);
  assign ready_o = !snap_v_q || snap_ready_i;
  assign fire    = valid_i && ready_o;
  assign seq_inc = seq_q + 16'd1;

  always_comb begin
    sum_d = sum_q;
    seq_d = seq_q;
    emit  = 1'b0;
    case (mode)
      MODE_CLEAR:    sum_d = '0;
      MODE_ADD_WORD: sum_d = sum_q + {16'd0, data_i};
      MODE_ADD_BYTE: sum_d = sum_q + {16'd0, data_i[7:0], 8'd0};
      MODE_FINISH:   emit  = 1'b1;
      MODE_BUMP_SEQ: begin
        seq_d = seq_inc;
        // no sum increment when the counter wraps to zero
        if (seq_inc != '0) begin
          sum_d = sum_q + 32'd1;
        end
        emit  = 1'b1;
      end
      MODE_LOAD_SEQ: seq_d = data_i;
      default: ;
    endcase
  end

  assign snap_v_d = fire ? emit : (snap_v_q && !snap_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      seq_q    <= '0;
      snap_v_q <= 1'b0;
    end else begin
      snap_v_q <= snap_v_d;
      if (fire) begin
        sum_q <= sum_d;
        seq_q <= seq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      snap_q.sum <= sum_d;
      snap_q.seq <= seq_d;
    end
  end

  assign snap_valid_o = snap_v_q;
  assign snap_o       = snap_q;

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && mode_i == MODE_CLEAR) |=> (sum_q == '0))
    else $error("sum not cleared");

  a_bump_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && mode_i == MODE_BUMP_SEQ) |=> (seq_q == $past(seq_q) + 16'd1))
    else $error("sequence not incremented on bump");

  a_bump_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && mode_i == MODE_BUMP_SEQ && seq_q != 16'hFFFF)
      |=> (sum_q == $past(sum_q) + 32'd1))
    else $error("sum not incremented on bump");

  a_unused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && mode_i > MODE_LOAD_SEQ)
      |=> ($stable(sum_q) && $stable(seq_q)))
    else $error("unused mode changed state");

  a_snap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap_v_q && !snap_ready_i) |=> (snap_v_q && $stable(snap_q)))
    else $error("snapshot lost while stalled");

endmodule

`default_nettype wire

/* sv/cks_fold.sv */
// fold stage: end-around carry fold, inversion and result register
// depends on cks_pkg; takes snapshots from cks_accum
`default_nettype none

module cks_fold import cks_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic snap_valid_i,
  output logic      snap_ready_o,
  input  snap_t     snap_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [WordW-1:0] checksum_o,
  output logic [WordW-1:0] sequence_res_o
);

  logic [WordW:0]   fold1;
  logic [WordW-1:0] fold2;
  logic             out_v_q;
  logic [WordW-1:0] csum_q, seq_q;
  logic             fire;

  // two folds suffice: the first leaves at most one carry
  assign fold1 = {1'b0, snap_i.sum[SumW-1:WordW]} + {1'b0, snap_i.sum[WordW-1:0]};
  assign fold2 = fold1[WordW-1:0] + {{(WordW-1){1'b0}}, fold1[WordW]};

  assign snap_ready_o = !out_v_q || out_ready_i;
  assign fire         = snap_valid_i && snap_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (snap_ready_o) begin
      out_v_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      csum_q <= ~fold2;
      seq_q  <= snap_i.seq;
    end
  end

  assign out_valid_o    = out_v_q;
  assign checksum_o     = csum_q;
  assign sequence_res_o = seq_q;

endmodule

`default_nettype wire

/* sv/internet_checksum_with_seq_update_core.sv */
// top level of the streaming ones' complement checksum engine
// depends on cks_pkg, cks_accum and cks_fold
`default_nettype none

// Streaming ones' complement checksum with sequence-number update. Each
// transfer on the input channel carries a mode (clear, add word, add odd
// byte, finish, bump sequence, load sequence) and a 16-bit word. Finish and
// bump return one result (checksum and sequence); the other modes return
// none. One item is taken per cycle with no bubbles: an input register, the
// accumulate stage (one 32-bit add updating the running sum) and the fold
// stage feeding the result register lie in order between the input transfer
// and out_valid_o. Throughput is limited only by backpressure on the result
// channel.
module internet_checksum_with_seq_update_core import cks_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire logic [WordW-1:0] data_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [WordW-1:0]      checksum_o,
  output logic [WordW-1:0]      sequence_res_o
);

  logic             in_v_q;
  logic [ModeW-1:0] mode_q;
  logic [WordW-1:0] data_q;
  logic             acc_ready;
  logic             snap_valid, snap_ready;
  snap_t            snap;

  assign in_ready_o = !in_v_q || acc_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      data_q <= data_word_i;
    end
  end

  cks_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_v_q),
    .ready_o      (acc_ready),
    .mode_i       (mode_q),
    .data_i       (data_q),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  cks_fold u_fold (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_valid_i   (snap_valid),
    .snap_ready_o   (snap_ready),
    .snap_i         (snap),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .checksum_o     (checksum_o),
    .sequence_res_o (sequence_res_o)
  );

endmodule

`default_nettype wire

/* sim/tb_internet_checksum_with_seq_update_core.sv */
// self-checking testbench for the streaming ones' complement checksum core
// depends on cks_pkg and internet_checksum_with_seq_update_core
`timescale 1ns / 1ps

module tb_internet_checksum_with_seq_update_core;
  import cks_pkg::*;

  // mode codes the block treats as no-ops
  localparam logic [ModeW-1:0] MODE_RSVD6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_RSVD7 = 3'd7;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    logic [WordW-1:0] checksum;
    logic [WordW-1:0] seq;
  } cks_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [ModeW-1:0] mode_i = '0;
  logic [WordW-1:0] data_word_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [WordW-1:0] checksum_o;
  logic [WordW-1:0] sequence_res_o;

  // predictor state
  logic [SumW-1:0]  model_sum;
  logic [WordW-1:0] model_seq;
  cks_result_t      pending_results[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int items_sent = 0;
  int results_seen = 0;

  internet_checksum_with_seq_update_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .data_word_i   (data_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .checksum_o    (checksum_o),
    .sequence_res_o(sequence_res_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [WordW-1:0] fold_invert(input logic [SumW-1:0] s);
    logic [SumW-1:0] f;
    f = {16'h0000, s[31:16]} + {16'h0000, s[15:0]};
    f = f + {16'h0000, f[31:16]};
    return ~f[15:0];
  endfunction

  function automatic void predict_item(input logic [ModeW-1:0] mode,
                                       input logic [WordW-1:0] data);
    case (mode)
      MODE_CLEAR:    model_sum = '0;
      MODE_ADD_WORD: model_sum = model_sum + {16'h0000, data};
      MODE_ADD_BYTE: model_sum = model_sum + {16'h0000, data[7:0], 8'h00};
      MODE_FINISH:   pending_results.push_back('{fold_invert(model_sum), model_seq});
      MODE_BUMP_SEQ: begin
        model_seq = model_seq + 16'd1;
        // a wrap to zero leaves the sum alone
        if (model_seq != '0) model_sum = model_sum + 32'd1;
        pending_results.push_back('{fold_invert(model_sum), model_seq});
      end
      MODE_LOAD_SEQ: model_seq = data;
      default: ;
    endcase
  endfunction

  function automatic void note_error(input string msg);
    if (err_cnt < 10) $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endfunction

  // receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99, 0) >= stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    cks_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result checksum=%h seq=%h",
                             checksum_o, sequence_res_o));
      end else begin
        want = pending_results.pop_front();
        if (checksum_o !== want.checksum)
          note_error($sformatf("checksum exp=%h got=%h", want.checksum, checksum_o));
        if (sequence_res_o !== want.seq)
          note_error($sformatf("sequence exp=%h got=%h", want.seq, sequence_res_o));
      end
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [ModeW-1:0] mode, input logic [WordW-1:0] data);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    data_word_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_item(mode, data);
    items_sent++;
  endtask

  // hold off the sender until every pending result is back
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_after_reset;
    send_item(MODE_FINISH, 16'h0000);
    send_item(MODE_BUMP_SEQ, 16'hFFFF);
    drain();
  endtask

  task automatic test_word_sums;
    // clear keeps the sequence; 0x1ffff needs both folds
    send_item(MODE_CLEAR, 16'hFFFF);
    send_item(MODE_ADD_WORD, 16'hFFFF);
    send_item(MODE_ADD_WORD, 16'hFFFF);
    send_item(MODE_ADD_WORD, 16'h0001);
    send_item(MODE_FINISH, 16'h0000);
    send_item(MODE_ADD_WORD, 16'h0000);
    send_item(MODE_FINISH, 16'hFFFF);
    drain();
  endtask

  task automatic test_odd_byte;
    // upper byte of the word must be dropped
    send_item(MODE_CLEAR, 16'h0000);
    send_item(MODE_ADD_BYTE, 16'hFF00);
    send_item(MODE_ADD_BYTE, 16'h5AFF);
    send_item(MODE_FINISH, 16'h0000);
    drain();
  endtask

  task automatic test_sequence_wrap;
    send_item(MODE_LOAD_SEQ, 16'hFFFE);
    send_item(MODE_BUMP_SEQ, 16'h0000);
    send_item(MODE_BUMP_SEQ, 16'h0000);
    send_item(MODE_BUMP_SEQ, 16'h0000);
    drain();
  endtask

  task automatic test_unused_modes;
    send_item(MODE_RSVD6, 16'hFFFF);
    send_item(MODE_RSVD7, 16'h1234);
    send_item(MODE_FINISH, 16'h0000);
    drain();
  endtask

  task automatic test_long_sum;
    // 256 x 0xffff carries well into the upper half of the sum
    send_item(MODE_CLEAR, 16'h0000);
    repeat (256) send_item(MODE_ADD_WORD, 16'hFFFF);
    send_item(MODE_FINISH, 16'h0000);
    send_item(MODE_ADD_WORD, 16'h0002);
    send_item(MODE_FINISH, 16'h0000);
    send_item(MODE_BUMP_SEQ, 16'h0000);
    drain();
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int n_items);
    int start_cnt;
    int n_words;
    start_cnt = items_sent;
    idle_pct  = idle;
    stall_pct = stall;
    while (items_sent - start_cnt < n_items) begin
      case ($urandom_range(9, 0))
        0, 1: begin
          // noise, any mode including the unused ones
          repeat ($urandom_range(4, 1))
            send_item(ModeW'($urandom_range(7, 0)), WordW'($urandom));
        end
        2: begin
          // sequence load, often close to the wrap point
          if ($urandom_range(1, 0))
            send_item(MODE_LOAD_SEQ, 16'hFFFF - WordW'($urandom_range(3, 0)));
          else
            send_item(MODE_LOAD_SEQ, WordW'($urandom));
          repeat ($urandom_range(5, 1)) send_item(MODE_BUMP_SEQ, WordW'($urandom));
        end
        default: begin
          // well-formed message: usually a clear, words, optional odd byte, finish, bumps
          if ($urandom_range(9, 0) != 0) send_item(MODE_CLEAR, WordW'($urandom));
          n_words = $urandom_range(24, 1);
          repeat (n_words) begin
            if ($urandom_range(3, 0) == 0)
              send_item(MODE_ADD_WORD, 16'hFFFF - WordW'($urandom_range(15, 0)));
            else
              send_item(MODE_ADD_WORD, WordW'($urandom));
          end
          if ($urandom_range(1, 0)) send_item(MODE_ADD_BYTE, WordW'($urandom));
          send_item(MODE_FINISH, WordW'($urandom));
          repeat ($urandom_range(2, 0)) send_item(MODE_BUMP_SEQ, WordW'($urandom));
        end
      endcase
    end
    drain();
  endtask

  initial begin
    model_sum = '0;
    model_seq = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_word_sums();
    test_odd_byte();
    test_sequence_wrap();
    test_unused_modes();
    test_long_sum();
    test_random_traffic(0, 0, 370);
    test_random_traffic(58, 0, 370);
    test_random_traffic(0, 58, 370);
    test_random_traffic(30, 30, 370);

    if (pending_results.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("run covered %0d input transfers and %0d result transfers", items_sent,
             results_seen);
    $display("incl. sequence wrap, long sums, odd bytes, unused modes, 4 idle mixes");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
sv/cks_pkg.sv
sv/cks_accum.sv
sv/cks_fold.sv
sv/internet_checksum_with_seq_update_core.sv
sim/tb_internet_checksum_with_seq_update_core.sv
